FILE: hw/rtl/npm_pkg.sv
// Package with shared types and constants for the nearest point matcher.
package npm_pkg;

  localparam int COORD_W  = 32;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 10;
  localparam int DIMS_W   = 2;
  localparam int THRESH_W = 48;
  localparam int CFG_IDX_W = 1;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_LOADED  = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_MATCH   = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOMATCH = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_CLEARED = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_DIMENSIONS      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_THRESHOLD = 1'd1;

  localparam logic [DIMS_W-1:0]   DIMS_RESET   = 2'd3;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 48'd1;

  // Control that travels with each target down the chain.
  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

FILE: hw/rtl/npm_if.sv
// Interfaces for the input and result channels of the nearest point matcher.
interface npm_in_if;
  logic                              valid;
  logic                              ready;
  logic [npm_pkg::KIND_W-1:0]        kind;
  logic signed [npm_pkg::COORD_W-1:0] coord_x;
  logic signed [npm_pkg::COORD_W-1:0] coord_y;
  logic signed [npm_pkg::COORD_W-1:0] coord_z;
  modport source (output valid, kind, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, kind, coord_x, coord_y, coord_z, output ready);
endinterface

interface npm_out_if;
  logic                         valid;
  logic                         ready;
  logic [npm_pkg::STATUS_W-1:0] status;
  logic [npm_pkg::INDEX_W-1:0]  match_index;
  modport source (output valid, status, match_index, input ready);
  modport sink   (input valid, status, match_index, output ready);
endinterface

FILE: hw/rtl/npm_axis_cell.sv
// One axis cell: adds the squared difference of one coordinate to the running sum when en is high.
module npm_axis_cell #(
  parameter int AXIS = 0,
  parameter int CW   = 32,
  parameter int SW   = 66,
  parameter int AW   = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [CW-1:0]     query,
  input  npm_pkg::ctl_t     ctl_i,
  input  logic [AW-1:0]     idx_i,
  input  logic [3*CW-1:0]   pt_i,
  input  logic [SW-1:0]     sum_i,
  output npm_pkg::ctl_t     ctl_o,
  output logic [AW-1:0]     idx_o,
  output logic [3*CW-1:0]   pt_o,
  output logic [SW-1:0]     sum_o
);
  import npm_pkg::*;

  logic signed [CW:0] diff;
  logic [CW-1:0]      mag_a_r;
  ctl_t               ctl_a_r, ctl_b_r;
  logic [AW-1:0]      idx_a_r, idx_b_r;
  logic [3*CW-1:0]    pt_a_r, pt_b_r;
  logic [SW-1:0]      sum_a_r, sum_b_r;
  logic [2*CW-1:0]    sq;

  assign diff = $signed({query[CW-1], query})
              - $signed({pt_i[AXIS*CW+CW-1], pt_i[AXIS*CW +: CW]});
  // The difference never reaches -2^CW, so its magnitude fits in CW bits.
  assign sq = mag_a_r * mag_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
    end else begin
      ctl_a_r <= ctl_i;
      ctl_b_r <= ctl_a_r;
    end
    mag_a_r <= diff[CW] ? CW'(-diff) : diff[CW-1:0];
    idx_a_r <= idx_i;
    pt_a_r  <= pt_i;
    sum_a_r <= sum_i;
    idx_b_r <= idx_a_r;
    pt_b_r  <= pt_a_r;
    sum_b_r <= en ? sum_a_r + SW'(sq) : sum_a_r;
  end

  assign ctl_o = ctl_b_r;
  assign idx_o = idx_b_r;
  assign pt_o  = pt_b_r;
  assign sum_o = sum_b_r;
endmodule

FILE: hw/rtl/npm_best_cell.sv
// End cell of the chain: keeps the first target with the strictly smallest sum.
module npm_best_cell #(
  parameter int SW = 66,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  npm_pkg::ctl_t ctl_i,
  input  logic [AW-1:0] idx_i,
  input  logic [SW-1:0] sum_i,
  output logic [SW-1:0] best_sum_o,
  output logic [AW-1:0] best_idx_o,
  output logic          done_o
);
  import npm_pkg::*;

  logic [SW-1:0] best_sum_r;
  logic [AW-1:0] best_idx_r;
  logic          done_r;
  logic          take;

  // Index zero is always the first target of a scan.
  assign take = ctl_i.valid && ((idx_i == '0) || (sum_i < best_sum_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= ctl_i.valid && ctl_i.last;
    end
    if (take) begin
      best_sum_r <= sum_i;
      best_idx_r <= idx_i;
    end
  end

  assign best_sum_o = best_sum_r;
  assign best_idx_o = best_idx_r;
  assign done_o     = done_r;
endmodule

FILE: hw/rtl/nearest_point_matcher.sv
// Top level of the nearest point matcher: target table, scan control and the cell chain.
// Load, clear and unknown words answer in the cycle after acceptance.
// A query scans the stored targets in index order: one target leaves the table
// memory per cycle, then passes the memory read stage, three axis cells of two stages
// each and the best cell. One word is in work at a time. Reset (synchronous, active low)
// empties the table and sets dimensions to 3 and the match threshold to 1.
module nearest_point_matcher #(
  parameter int MAX_TARGETS = 1024,
  parameter int COORD_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  npm_in_if.sink                         in_ch,
  npm_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [npm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [npm_pkg::THRESH_W-1:0]   cfg_data
);
  import npm_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CNTW = $clog2(MAX_TARGETS + 1);
  // Sum of three squares of CW-bit magnitudes.
  localparam int SW   = 2 * CW + 2;
  localparam int CMPW = (SW > THRESH_W) ? SW : THRESH_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]          state_r;
  logic [DIMS_W-1:0]   dims_r;
  logic [THRESH_W-1:0] thresh_r;
  logic [CNTW-1:0]     count_r;
  logic [CNTW-1:0]     scan_r;
  logic                issuing_r;
  logic [CW-1:0]       qx_r, qy_r, qz_r;

  logic [3*CW-1:0]     table_mem [MAX_TARGETS];
  ctl_t                rd_ctl_r;
  logic [AW-1:0]       rd_idx_r;
  logic [3*CW-1:0]     rd_pt_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [INDEX_W-1:0]  out_index_r;

  logic                out_free, accept, full, scan_last;
  logic [3*CW-1:0]     in_pt;
  logic [31:0]         load_idx_ext, best_idx_ext;
  logic                is_match;
  logic [STATUS_W-1:0] q_status;
  logic [INDEX_W-1:0]  q_index;

  // Chain wiring: stage k feeds axis cell k.
  ctl_t            ch_ctl [4];
  logic [AW-1:0]   ch_idx [4];
  logic [3*CW-1:0] ch_pt  [4];
  logic [SW-1:0]   ch_sum [4];
  logic [CW-1:0]   q_axis [3];
  logic [SW-1:0]   best_sum;
  logic [AW-1:0]   best_idx;
  logic            scan_done;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign accept = in_ch.valid && in_ch.ready;
  assign full = (count_r == CNTW'(MAX_TARGETS));
  assign scan_last = (scan_r == count_r - CNTW'(1));
  assign in_pt = {in_ch.coord_z[CW-1:0], in_ch.coord_y[CW-1:0], in_ch.coord_x[CW-1:0]};
  assign load_idx_ext = 32'(count_r);
  assign best_idx_ext = 32'(best_idx);

  // The threshold is exclusive; a distance that does not fit 48 bits never matches.
  assign is_match = (CMPW'(best_sum) < CMPW'(thresh_r));
  assign q_status = is_match ? STATUS_MATCH : STATUS_NOMATCH;
  assign q_index  = is_match ? best_idx_ext[INDEX_W-1:0] : '0;

  assign q_axis[0] = qx_r;
  assign q_axis[1] = qy_r;
  assign q_axis[2] = qz_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r   <= DIMS_RESET;
      thresh_r <= THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIMENSIONS:      dims_r   <= cfg_data[DIMS_W-1:0];
        REG_MATCH_THRESHOLD: thresh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Target table: written on load, read one entry per cycle during a scan.
  always_ff @(posedge clk) begin
    if (accept && in_ch.kind == KIND_LOAD && !full) begin
      table_mem[count_r[AW-1:0]] <= in_pt;
    end
    rd_pt_r  <= table_mem[scan_r[AW-1:0]];
    rd_idx_r <= scan_r[AW-1:0];
  end

  // Control, scan sequencing and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      issuing_r   <= 1'b0;
      rd_ctl_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_ctl_r.valid <= issuing_r;
      rd_ctl_r.last  <= scan_last;
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (issuing_r) begin
        scan_r <= scan_r + CNTW'(1);
        if (scan_last) begin
          issuing_r <= 1'b0;
        end
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (in_ch.kind)
              KIND_LOAD: begin
                out_valid_r <= 1'b1;
                if (full) begin
                  out_status_r <= STATUS_FULL;
                  out_index_r  <= '0;
                end else begin
                  out_status_r <= STATUS_LOADED;
                  out_index_r  <= load_idx_ext[INDEX_W-1:0];
                  count_r      <= count_r + CNTW'(1);
                end
              end
              KIND_QUERY: begin
                if (count_r == '0) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= STATUS_NOMATCH;
                  out_index_r  <= '0;
                end else begin
                  scan_r    <= '0;
                  issuing_r <= 1'b1;
                  state_r   <= ST_SCAN;
                end
              end
              KIND_CLEAR: begin
                count_r      <= '0;
                out_valid_r  <= 1'b1;
                out_status_r <= STATUS_CLEARED;
                out_index_r  <= '0;
              end
              default: begin
                out_valid_r  <= 1'b1;
                out_status_r <= STATUS_NOMATCH;
                out_index_r  <= '0;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            if (out_free) begin
              out_valid_r  <= 1'b1;
              out_status_r <= q_status;
              out_index_r  <= q_index;
              state_r      <= ST_IDLE;
            end else begin
              state_r <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          // The best cell keeps its result until the next scan starts.
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= q_status;
            out_index_r  <= q_index;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // The query point is captured on acceptance and held for the whole scan.
  always_ff @(posedge clk) begin
    if (accept) begin
      qx_r <= in_ch.coord_x[CW-1:0];
      qy_r <= in_ch.coord_y[CW-1:0];
      qz_r <= in_ch.coord_z[CW-1:0];
    end
  end

  assign ch_ctl[0] = rd_ctl_r;
  assign ch_idx[0] = rd_idx_r;
  assign ch_pt[0]  = rd_pt_r;
  assign ch_sum[0] = '0;

  // Three axis cells in a row; cell k adds its axis only when k is below dimensions.
  for (genvar k = 0; k < 3; k++) begin : g_axis
    npm_axis_cell #(
      .AXIS (k),
      .CW   (CW),
      .SW   (SW),
      .AW   (AW)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (dims_r > DIMS_W'(k)),
      .query (q_axis[k]),
      .ctl_i (ch_ctl[k]),
      .idx_i (ch_idx[k]),
      .pt_i  (ch_pt[k]),
      .sum_i (ch_sum[k]),
      .ctl_o (ch_ctl[k+1]),
      .idx_o (ch_idx[k+1]),
      .pt_o  (ch_pt[k+1]),
      .sum_o (ch_sum[k+1])
    );
  end

  npm_best_cell #(
    .SW (SW),
    .AW (AW)
  ) u_best (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (ch_ctl[3]),
    .idx_i      (ch_idx[3]),
    .sum_i      (ch_sum[3]),
    .best_sum_o (best_sum),
    .best_idx_o (best_idx),
    .done_o     (scan_done)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.match_index = out_index_r;
endmodule
